### rtl/gsmc_pkg.sv
// ----------------------------------------------------------------------------
// gsmc_pkg
// Shared types, constants and helpers for the grid set-merge maze carver.
// ----------------------------------------------------------------------------
`default_nettype none

package gsmc_pkg;

  localparam int MaxSideDef = 32;  // default grid side limit
  localparam int CoordLimit = 32;  // coordinates are 5 bits wide
  localparam int CoordW     = 5;
  localparam int SideW      = 6;   // width/height registers
  localparam int CountW     = 11;  // set count, up to 1024
  localparam int CfgIdxW    = 1;
  localparam int CfgDataW   = 6;

  localparam logic [SideW-1:0]  WidthReset  = SideW'(10);
  localparam logic [SideW-1:0]  HeightReset = SideW'(10);
  localparam logic [CountW-1:0] CountMax    = CountW'(1024);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    REQ_CLEAR = 1'b0,
    REQ_EDGE  = 1'b1
  } req_type_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CHECK,
    ST_WALK1,
    ST_WALK2,
    ST_SWEEP,
    ST_RESULT
  } walk_state_e;

  typedef struct packed {
    logic              req_type;
    logic [CoordW-1:0] first_x;
    logic [CoordW-1:0] first_y;
    logic [CoordW-1:0] second_x;
    logic [CoordW-1:0] second_y;
  } req_t;

  typedef struct packed {
    logic              passage_opened;
    logic              status;
    logic [CountW-1:0] sets_left;
    logic              maze_complete;
  } res_t;

  // Clamp a side register to 1 .. lim.
  function automatic logic [SideW-1:0] clamp_side(input logic [SideW-1:0] v,
                                                  input logic [SideW-1:0] lim);
    logic [SideW-1:0] r;
    r = v;
    if (v == '0) begin
      r = SideW'(1);
    end else if (v > lim) begin
      r = lim;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/gsmc_parent_mem.sv
// ----------------------------------------------------------------------------
// gsmc_parent_mem
// Parent-pointer store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gsmc_parent_mem
  import gsmc_pkg::*;
#(
  parameter int DEPTH  = MaxSideDef * MaxSideDef,
  parameter int ADDR_W = $clog2(MaxSideDef * MaxSideDef)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [ADDR_W-1:0] wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [ADDR_W-1:0] rdata_o
);

  logic [ADDR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

### rtl/gsmc_walker.sv
// ----------------------------------------------------------------------------
// gsmc_walker
// Request sequencer: root walks, union write, clear sweep and set count.
// ----------------------------------------------------------------------------
`default_nettype none

module gsmc_walker
  import gsmc_pkg::*;
#(
  parameter int MAX_SIDE = MaxSideDef
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  req_valid_i,
  output logic                                       req_ready_o,
  input  wire req_t                                  req_i,
  input  wire logic [SideW-1:0]                      width_i,
  input  wire logic [SideW-1:0]                      height_i,
  output logic                                       res_valid_o,
  input  wire logic                                  res_ready_i,
  output res_t                                       res_o,
  output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]       mem_raddr_o,
  input  wire logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]  mem_rdata_i,
  output logic                                       mem_we_o,
  output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]       mem_waddr_o,
  output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]       mem_wdata_o
);

  localparam int CellCount = MAX_SIDE * MAX_SIDE;
  localparam int IdxW      = $clog2(CellCount);
  localparam int SideLim   = (MAX_SIDE < CoordLimit) ? MAX_SIDE : CoordLimit;
  localparam logic [SideW-1:0]  Lim       = SideW'(SideLim);
  localparam logic [IdxW-1:0]   LastCell  = IdxW'(CellCount - 1);
  localparam logic [CountW-1:0] CountInit =
    CountW'(32'(clamp_side(WidthReset, Lim)) * 32'(clamp_side(HeightReset, Lim)));

  walk_state_e state_q, state_d;

  req_t              req_q;
  logic [IdxW-1:0]   cur_q, cur_d;
  logic [IdxW-1:0]   root1_q, root1_d;
  logic [IdxW-1:0]   sweep_q, sweep_d;
  logic [CountW-1:0] count_q, count_d;
  logic              opened_q, opened_d;
  logic              status_q, status_d;

  logic [IdxW-1:0] idx1, idx2;
  logic            out_of_grid;
  logic            at_root;
  logic            accept;

  // cell (x,y) sits at y*MAX_SIDE+x; only used when inside the grid
  assign idx1 = IdxW'(32'(req_q.first_y) * MAX_SIDE + 32'(req_q.first_x));
  assign idx2 = IdxW'(32'(req_q.second_y) * MAX_SIDE + 32'(req_q.second_x));

  assign out_of_grid = ({1'b0, req_q.first_x}  >= width_i)  ||
                       ({1'b0, req_q.first_y}  >= height_i) ||
                       ({1'b0, req_q.second_x} >= width_i)  ||
                       ({1'b0, req_q.second_y} >= height_i);

  assign at_root = (mem_rdata_i == cur_q);
  assign accept  = req_valid_i && req_ready_o;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (sweep_q == LastCell) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid_i) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (req_q.req_type == REQ_CLEAR) begin
          state_d = ST_SWEEP;
        end else if (out_of_grid) begin
          state_d = ST_RESULT;
        end else begin
          state_d = ST_WALK1;
        end
      end
      ST_WALK1: begin
        if (at_root) state_d = ST_WALK2;
      end
      ST_WALK2: begin
        if (at_root) state_d = ST_RESULT;
      end
      ST_SWEEP: begin
        if (sweep_q == LastCell) state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (res_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_INIT;
    endcase
  end

  // outputs
  always_comb begin
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;
    mem_raddr_o = cur_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = sweep_q;
    mem_wdata_o = sweep_q;
    unique case (state_q)
      ST_INIT, ST_SWEEP: begin
        mem_we_o = 1'b1;
      end
      ST_IDLE: begin
        req_ready_o = 1'b1;
      end
      ST_CHECK: begin
        mem_raddr_o = idx1;
      end
      ST_WALK1: begin
        mem_raddr_o = at_root ? idx2 : mem_rdata_i;
      end
      ST_WALK2: begin
        mem_raddr_o = mem_rdata_i;
        // second root found in another set: hang it under the first root
        if (at_root && (cur_q != root1_q)) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = cur_q;
          mem_wdata_o = root1_q;
        end
      end
      ST_RESULT: begin
        res_valid_o = 1'b1;
      end
      default: ;
    endcase
  end

  // datapath next values
  always_comb begin
    cur_d    = cur_q;
    root1_d  = root1_q;
    sweep_d  = sweep_q;
    count_d  = count_q;
    opened_d = opened_q;
    status_d = status_q;
    case (state_q)
      ST_INIT, ST_SWEEP: begin
        sweep_d = (sweep_q == LastCell) ? '0 : sweep_q + IdxW'(1);
      end
      ST_CHECK: begin
        opened_d = 1'b0;
        status_d = 1'b0;
        cur_d    = idx1;
        if (req_q.req_type == REQ_CLEAR) begin
          count_d = CountW'(32'(width_i) * 32'(height_i));
        end else if (out_of_grid) begin
          status_d = 1'b1;
        end
      end
      ST_WALK1: begin
        if (at_root) begin
          root1_d = cur_q;
          cur_d   = idx2;
        end else begin
          cur_d = mem_rdata_i;
        end
      end
      ST_WALK2: begin
        if (at_root) begin
          if (cur_q != root1_q) begin
            opened_d = 1'b1;
            if (count_q != '0) count_d = count_q - CountW'(1);
          end
        end else begin
          cur_d = mem_rdata_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_INIT;
      sweep_q  <= '0;
      count_q  <= CountInit;
      opened_q <= 1'b0;
      status_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      sweep_q  <= sweep_d;
      count_q  <= count_d;
      opened_q <= opened_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    root1_q <= root1_d;
    if (accept) begin
      req_q <= req_i;
    end
  end

  assign res_o.passage_opened = opened_q;
  assign res_o.status         = status_q;
  assign res_o.sets_left      = count_q;
  assign res_o.maze_complete  = (count_q == CountW'(1));

endmodule

`default_nettype wire

### rtl/grid_set_merge_maze_carver.sv
// ----------------------------------------------------------------------------
// grid_set_merge_maze_carver
// Kruskal maze carving over a union-find forest kept in one parent memory.
// ----------------------------------------------------------------------------
// Edge beat: the sequencer walks the parent chains of the two cells, one memory
//   read per step, joins the two sets if their roots differ, then hands the
//   result to the output register. An out-of-grid edge skips the walks.
//   Clear rewrites every parent-memory entry to point at itself, one entry per
//   cycle, and reloads the set count from the grid size.
// Reset: an init sweep over all MAX_SIDE*MAX_SIDE entries runs first, with req_ready_o low.
`default_nettype none

module grid_set_merge_maze_carver
  import gsmc_pkg::*;
#(
  parameter int MAX_SIDE = MaxSideDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // request channel
  input  wire logic                req_valid_i,
  output logic                     req_ready_o,
  input  wire req_t                req_i,
  // result channel
  output logic                     res_valid_o,
  input  wire logic                res_ready_i,
  output res_t                     res_o,
  // configuration writes
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  localparam int CellCount = MAX_SIDE * MAX_SIDE;
  localparam int IdxW      = $clog2(CellCount);
  localparam int SideLim   = (MAX_SIDE < CoordLimit) ? MAX_SIDE : CoordLimit;
  localparam logic [SideW-1:0] Lim = SideW'(SideLim);

  // config registers, raw values; clamped before use
  logic [SideW-1:0] width_q, height_q;
  logic [SideW-1:0] width_eff, height_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_WIDTH:  width_q  <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i;
      endcase
    end
  end

  assign width_eff  = clamp_side(width_q, Lim);
  assign height_eff = clamp_side(height_q, Lim);

  // parent memory port
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr, mem_wdata, mem_raddr, mem_rdata;

  gsmc_parent_mem #(
    .DEPTH  (CellCount),
    .ADDR_W (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // sequencer
  logic walk_valid, walk_ready;
  res_t walk_res;

  gsmc_walker #(
    .MAX_SIDE (MAX_SIDE)
  ) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .width_i     (width_eff),
    .height_i    (height_eff),
    .res_valid_o (walk_valid),
    .res_ready_i (walk_ready),
    .res_o       (walk_res),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata)
  );

  // output register: the walker is free to take the next beat while the
  // previous result waits here
  logic out_valid_q, out_valid_d;
  res_t out_q;

  assign walk_ready  = !out_valid_q || res_ready_i;
  assign out_valid_d = (walk_valid && walk_ready) ||
                       (out_valid_q && !res_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (walk_valid && walk_ready) begin
      out_q <= walk_res;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------

  // one beat in flight: the sequencer drops ready right after a request beat
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_o |=> !req_ready_o)
    else $error("request accepted while another is in flight");

  // an out-of-grid edge never carves a passage
  a_status_no_carve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status |-> !res_o.passage_opened)
    else $error("passage opened on an out-of-grid edge");

  // set count never exceeds the largest grid
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.sets_left <= CountMax))
    else $error("set count out of range");

endmodule

`default_nettype wire
